// ----- rtl/core/landmark_nearest_match_table_defines.svh -----
// Assertion macros shared by the landmark match table RTL.
`ifndef LANDMARK_NEAREST_MATCH_TABLE_DEFINES_SVH
`define LANDMARK_NEAREST_MATCH_TABLE_DEFINES_SVH
`ifndef SYNTH
`define LNM_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define LNM_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition");
`else
`define LNM_ASSERT_IMPL(label, clk, rst_n, prop)
`define LNM_ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ----- rtl/core/lnm_pkg.sv -----
// Shared types and constants of the landmark match table.
package lnm_pkg;
    localparam int MaxEntries = 64;
    localparam int CoordBits  = 20;
    localparam int IdxW       = $clog2(MaxEntries);
    localparam int CntW       = $clog2(MaxEntries + 1);
    localparam int DiffW      = CoordBits + 1;
    localparam int SqW        = 2 * DiffW;
    localparam int D2W        = SqW + 2;

    localparam logic [1:0] StMatched  = 2'd0;
    localparam logic [1:0] StAdded    = 2'd1;
    localparam logic [1:0] StRejected = 2'd2;
    localparam logic [1:0] StFull     = 2'd3;

    localparam logic [1:0] CfgSpacing   = 2'd0;
    localparam logic [1:0] CfgMatch     = 2'd1;
    localparam logic [1:0] CfgSmoothing = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_DECIDE, S_RDWAIT, S_WRITE, S_OUT
    } t_state;

    typedef struct packed {
        logic [CoordBits-1:0] x;
        logic [CoordBits-1:0] y;
        logic [CoordBits-1:0] z;
        logic [10:0]          radius;
        logic                 known;
        logic [15:0]          vote;
    } t_entry;
endpackage

// ----- rtl/core/landmark_nearest_match_table.sv -----
// Top level of the landmark nearest-match table.
// An observation beat is taken only while the block is idle. The single read port
// of the entry memory is swept once, one entry a cycle, through a two-stage distance unit.
// Then the chosen entry is read back, updated and written. One observation is in flight at
// a time. The result is held in an output register until taken; the block then passes
// through S_OUT back to idle before the next observation can be accepted. The memory
// holds no reset contents.
`include "landmark_nearest_match_table_defines.svh"
module landmark_nearest_match_table
    import lnm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [19:0]   i_obs_x,
    input  logic signed [19:0]   i_obs_y,
    input  logic signed [19:0]   i_obs_z,
    input  logic [10:0]          i_obs_radius_mm,
    input  logic                 i_target_only,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [1:0]           o_status,
    output logic [5:0]           o_entry_index,
    output logic [15:0]          o_entry_vote,
    output logic [10:0]          o_entry_radius_mm
);
    t_state r_state, n_state;
    logic [15:0] r_spacing, r_match;
    logic [8:0]  r_smooth;
    logic [CoordBits-1:0] r_ox, r_oy, r_oz;
    logic [10:0] r_orad;
    logic        r_tonly;
    logic [CntW-1:0] r_count;
    logic [CntW:0]   r_issue;
    logic [CntW:0]   r_recv;
    logic        r_found, r_close;
    logic [D2W-1:0] r_best_d2;
    logic [IdxW-1:0] r_best;
    logic        r_match_hit;
    logic [1:0]  r_st;
    logic [5:0]  r_idx;
    logic [15:0] r_vote;
    logic [10:0] r_rad;
    logic        r_ovalid;

    t_entry      rd_ent, wr_ent;
    logic        we;
    logic [IdxW-1:0] waddr, raddr;
    logic [D2W-1:0]  d2;
    logic [CntW:0]   lat;
    logic        recv_ok;
    logic [8:0]  q;
    logic [19:0] acc;
    logic [31:0] sp2, mt2;

    // Entry memory and distance pipeline.
    lnm_store u_store (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wr_ent),
        .i_raddr(raddr), .o_rdata(rd_ent)
    );
    lnm_dist u_dist (
        .i_clk(i_clk), .i_ox(r_ox), .i_oy(r_oy), .i_oz(r_oz),
        .i_ent(rd_ent), .o_d2(d2)
    );

    assign o_ready = (r_state == S_IDLE);
    assign sp2 = r_spacing * r_spacing;
    assign mt2 = r_match * r_match;
    assign q   = (r_smooth > 9'd256) ? 9'd256 : r_smooth;
    // Read data is registered in turn in the memory, the squares and the sum.
    assign lat = r_issue - (CntW+1)'(3);
    assign recv_ok = (r_state == S_SCAN) && (r_issue >= (CntW+1)'(3))
                     && (r_recv < (CntW+1)'(r_count));
    assign raddr = (r_state == S_SCAN) ? IdxW'(r_issue) : r_best;

    // Radius low-pass and write-back data.
    always_comb begin
        acc = 20'(q) * 20'(rd_ent.radius) + 20'(9'd256 - q) * 20'(r_orad) + 20'd128;
        wr_ent.x = r_ox;
        wr_ent.y = r_oy;
        wr_ent.z = r_oz;
        if (r_match_hit) begin
            wr_ent.vote   = (rd_ent.vote == 16'hFFFF) ? rd_ent.vote : rd_ent.vote + 16'd1;
            wr_ent.known  = 1'b1;
            wr_ent.radius = rd_ent.known ? acc[18:8] : r_orad;
        end else begin
            wr_ent.vote   = 16'd1;
            wr_ent.known  = 1'b0;
            wr_ent.radius = 11'd0;
        end
        we    = 1'b0;
        waddr = r_match_hit ? r_best : IdxW'(r_count);
        if (r_state == S_WRITE) begin
            we = r_match_hit || (r_st == StAdded);
        end
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_valid) n_state = S_SCAN;
            S_SCAN:   if (r_recv == (CntW+1)'(r_count)) n_state = S_DECIDE;
            S_DECIDE: n_state = S_RDWAIT;
            S_RDWAIT: n_state = S_WRITE;
            S_WRITE:  n_state = S_OUT;
            S_OUT:    if (!r_ovalid) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_spacing <= 16'd1000;
            r_match   <= 16'd500;
            r_smooth  <= 9'd205;
            r_count   <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state <= n_state;
            // Configuration writes.
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CfgSpacing:   r_spacing <= i_cfg_data;
                    CfgMatch:     r_match   <= i_cfg_data;
                    CfgSmoothing: r_smooth  <= i_cfg_data[8:0];
                    default:      ;
                endcase
            end
            if (r_state == S_WRITE && !r_match_hit && r_st == StAdded) begin
                r_count <= r_count + 1'b1;
            end
            if (r_state == S_WRITE) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_ox <= i_obs_x; r_oy <= i_obs_y; r_oz <= i_obs_z;
                r_orad <= i_obs_radius_mm; r_tonly <= i_target_only;
                r_issue <= '0; r_recv <= '0; r_found <= 1'b0; r_close <= 1'b0;
                r_best <= '0; r_best_d2 <= '0;
            end
            S_SCAN: begin
                r_issue <= r_issue + 1'b1;
                if (recv_ok) begin
                    r_recv <= r_recv + 1'b1;
                    if (d2 < D2W'(sp2)) r_close <= 1'b1;
                    if (!r_found || d2 < r_best_d2) begin
                        r_found <= 1'b1;
                        r_best_d2 <= d2;
                        r_best <= IdxW'(lat);
                    end
                end
            end
            S_DECIDE: begin
                r_match_hit <= r_found && (r_best_d2 < D2W'(mt2));
                if (r_found && (r_best_d2 < D2W'(mt2))) r_st <= StMatched;
                else if (r_close || r_tonly) r_st <= StRejected;
                else if (r_count == CntW'(MaxEntries)) r_st <= StFull;
                else r_st <= StAdded;
            end
            S_WRITE: begin
                if (r_match_hit || r_st == StAdded) begin
                    r_idx  <= 6'(waddr);
                    r_vote <= wr_ent.vote;
                    r_rad  <= wr_ent.radius;
                end else begin
                    r_idx <= '0; r_vote <= '0; r_rad <= '0;
                end
            end
            default: ;
        endcase
    end

    assign o_valid           = r_ovalid;
    assign o_status          = r_st;
    assign o_entry_index     = r_idx;
    assign o_entry_vote      = r_vote;
    assign o_entry_radius_mm = r_rad;

    `LNM_ASSERT_NEVER(a_count_bound, i_clk, i_rst_n, r_count > CntW'(MaxEntries))
    `LNM_ASSERT_IMPL(a_out_held, i_clk, i_rst_n, (o_valid && !i_ready) |=> o_valid)
    `LNM_ASSERT_NEVER(a_no_accept_busy, i_clk, i_rst_n, o_valid && o_ready)
endmodule

// ----- rtl/core/lnm_store.sv -----
// Landmark entry memory: one write port, one registered read port.
module lnm_store
    import lnm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [IdxW-1:0]   i_waddr,
    input  t_entry            i_wdata,
    input  logic [IdxW-1:0]   i_raddr,
    output t_entry            o_rdata
);
    t_entry r_mem [MaxEntries];
    t_entry r_rdata;

    // Synchronous write and read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/core/lnm_dist.sv -----
// Two-stage squared distance unit: squares, then sum.
module lnm_dist
    import lnm_pkg::*;
(
    input  logic                 i_clk,
    input  logic [CoordBits-1:0] i_ox,
    input  logic [CoordBits-1:0] i_oy,
    input  logic [CoordBits-1:0] i_oz,
    input  t_entry               i_ent,
    output logic [D2W-1:0]       o_d2
);
    logic [DiffW-1:0] dx, dy, dz, ax, ay, az;
    logic [SqW-1:0]   r_sx, r_sy, r_sz;
    logic [D2W-1:0]   r_d2;

    // Absolute differences of the sign-extended coordinates.
    always_comb begin
        dx = {i_ox[CoordBits-1], i_ox} - {i_ent.x[CoordBits-1], i_ent.x};
        dy = {i_oy[CoordBits-1], i_oy} - {i_ent.y[CoordBits-1], i_ent.y};
        dz = {i_oz[CoordBits-1], i_oz} - {i_ent.z[CoordBits-1], i_ent.z};
        ax = dx[DiffW-1] ? (~dx + 1'b1) : dx;
        ay = dy[DiffW-1] ? (~dy + 1'b1) : dy;
        az = dz[DiffW-1] ? (~dz + 1'b1) : dz;
    end

    // One multiplier per axis, registered before the sum.
    always_ff @(posedge i_clk) begin
        r_sx <= ax * ax;
        r_sy <= ay * ay;
        r_sz <= az * az;
        r_d2 <= D2W'(r_sx) + D2W'(r_sy) + D2W'(r_sz);
    end

    assign o_d2 = r_d2;
endmodule

// ----- dv/landmark_nearest_match_table_checker.sv -----
// Checker for the landmark match table: predicts each result beat and compares it.
`timescale 1ns / 1ps
module landmark_nearest_match_table_checker
    import lnm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic signed [19:0]   i_obs_x,
    input  logic signed [19:0]   i_obs_y,
    input  logic signed [19:0]   i_obs_z,
    input  logic [10:0]          i_obs_radius_mm,
    input  logic                 i_target_only,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic [1:0]           i_status,
    input  logic [5:0]           i_entry_index,
    input  logic [15:0]          i_entry_vote,
    input  logic [10:0]          i_entry_radius_mm,
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  index;
        logic [15:0] vote;
        logic [10:0] radius;
    } t_outcome;

    // Shadow copy of the landmark table and its settings.
    logic signed [19:0] tbl_x [MaxEntries];
    logic signed [19:0] tbl_y [MaxEntries];
    logic signed [19:0] tbl_z [MaxEntries];
    logic [10:0]        tbl_radius [MaxEntries];
    logic               tbl_known [MaxEntries];
    logic [15:0]        tbl_vote [MaxEntries];
    int                 tbl_count;
    logic [15:0]        spacing_mm;
    logic [15:0]        match_mm;
    logic [8:0]         smooth_q8;

    t_outcome outcome_q[$];
    int       fails;

    assign o_fail_count = fails;
    assign o_pending    = outcome_q.size();

    // Runs one observation against the shadow table and returns its outcome.
    function automatic t_outcome associate_landmark(
        logic signed [19:0] ox, logic signed [19:0] oy, logic signed [19:0] oz,
        logic [10:0] orad, logic obs_only);
        longint     dx, dy, dz;
        longint unsigned d2, best_d2, spacing2, match2;
        bit         found, too_close;
        int         best, q;
        int unsigned acc;
        t_outcome   res;
        spacing2  = longint'(spacing_mm) * longint'(spacing_mm);
        match2    = longint'(match_mm) * longint'(match_mm);
        found     = 0;
        too_close = 0;
        best      = 0;
        best_d2   = 0;
        res       = '{status: StRejected, index: 6'd0, vote: 16'd0, radius: 11'd0};
        for (int i = 0; i < tbl_count; i++) begin
            dx = longint'(ox) - longint'(tbl_x[i]);
            dy = longint'(oy) - longint'(tbl_y[i]);
            dz = longint'(oz) - longint'(tbl_z[i]);
            d2 = dx * dx + dy * dy + dz * dz;
            if (d2 < spacing2) too_close = 1;
            if (!found || d2 < best_d2) begin
                found   = 1;
                best_d2 = d2;
                best    = i;
            end
        end
        if (found && best_d2 < match2) begin
            // Matched: move the entry, bump its vote, set or smooth its radius.
            q = (smooth_q8 > 256) ? 256 : smooth_q8;
            tbl_x[best] = ox;
            tbl_y[best] = oy;
            tbl_z[best] = oz;
            if (tbl_vote[best] != 16'hFFFF) tbl_vote[best]++;
            if (!tbl_known[best]) begin
                tbl_radius[best] = orad;
                tbl_known[best]  = 1;
            end else begin
                acc = q * tbl_radius[best] + (256 - q) * orad + 128;
                tbl_radius[best] = acc[18:8];
            end
            res = '{status: StMatched, index: best[5:0], vote: tbl_vote[best],
                    radius: tbl_radius[best]};
        end else if (!too_close && !obs_only) begin
            if (tbl_count < MaxEntries) begin
                tbl_x[tbl_count]      = ox;
                tbl_y[tbl_count]      = oy;
                tbl_z[tbl_count]      = oz;
                tbl_radius[tbl_count] = '0;
                tbl_known[tbl_count]  = 0;
                tbl_vote[tbl_count]   = 16'd1;
                res = '{status: StAdded, index: tbl_count[5:0], vote: 16'd1, radius: 11'd0};
                tbl_count++;
            end else begin
                res.status = StFull;
            end
        end
        return res;
    endfunction

    // Track settings, predict on input beats, compare on result beats.
    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            tbl_count  <= 0;
            spacing_mm <= 16'd1000;
            match_mm   <= 16'd500;
            smooth_q8  <= 9'd205;
            fails      <= 0;
            outcome_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CfgSpacing:   spacing_mm <= i_cfg_data;
                    CfgMatch:     match_mm   <= i_cfg_data;
                    CfgSmoothing: smooth_q8  <= i_cfg_data[8:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                outcome_q = {outcome_q, associate_landmark(i_obs_x, i_obs_y, i_obs_z,
                                                           i_obs_radius_mm, i_target_only)};
            if (i_out_valid && i_out_ready) begin
                if (outcome_q.size() == 0) begin
                    if (fails < 10) $display("unexpected result beat: status %0d", i_status);
                    fails <= fails + 1;
                end else begin
                    want = outcome_q.pop_front();
                    if (want.status !== i_status || want.index !== i_entry_index ||
                        want.vote !== i_entry_vote || want.radius !== i_entry_radius_mm) begin
                        if (fails < 10)
                            $display("mismatch: expected st %0d idx %0d vote %0d rad %0d, %s",
                                     want.status, want.index, want.vote, want.radius,
                                     $sformatf("got st %0d idx %0d vote %0d rad %0d",
                                               i_status, i_entry_index, i_entry_vote,
                                               i_entry_radius_mm));
                        fails <= fails + 1;
                    end
                end
            end
        end
    end

endmodule

// ----- dv/landmark_nearest_match_table_tb.sv -----
// Testbench top for the landmark match table: stimulus, settings and verdict.
`timescale 1ns / 1ps
module landmark_nearest_match_table_tb;
    import lnm_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [15:0]        cfg_data;
    logic               obs_valid;
    logic               obs_ready;
    logic signed [19:0] obs_x, obs_y, obs_z;
    logic [10:0]        obs_radius;
    logic               target_only;
    logic               res_valid;
    logic               res_ready;
    logic [1:0]         status;
    logic [5:0]         entry_index;
    logic [15:0]        entry_vote;
    logic [10:0]        entry_radius;
    int                 fail_count;
    int                 pending;

    // Idling switch shared by both sides, and the request for a long result stall.
    bit                 idle_on;
    bit                 hold_req;
    logic signed [19:0] seen_x [$];
    logic signed [19:0] seen_y [$];
    logic signed [19:0] seen_z [$];

    landmark_nearest_match_table i_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_valid(obs_valid), .o_ready(obs_ready),
        .i_obs_x(obs_x), .i_obs_y(obs_y), .i_obs_z(obs_z),
        .i_obs_radius_mm(obs_radius), .i_target_only(target_only),
        .o_valid(res_valid), .i_ready(res_ready),
        .o_status(status), .o_entry_index(entry_index),
        .o_entry_vote(entry_vote), .o_entry_radius_mm(entry_radius)
    );

    landmark_nearest_match_table_checker i_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(obs_valid), .i_in_ready(obs_ready),
        .i_obs_x(obs_x), .i_obs_y(obs_y), .i_obs_z(obs_z),
        .i_obs_radius_mm(obs_radius), .i_target_only(target_only),
        .i_out_valid(res_valid), .i_out_ready(res_ready),
        .i_status(status), .i_entry_index(entry_index),
        .i_entry_vote(entry_vote), .i_entry_radius_mm(entry_radius),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Result side: random stalls, or a long hold-off when requested.
    always @(posedge clk) begin
        if (!rst_n) begin
            res_ready <= 1'b0;
        end else if (hold_req) begin
            res_ready <= 1'b0;
            repeat (400) @(posedge clk);
            hold_req  <= 1'b0;
            res_ready <= 1'b1;
        end else begin
            res_ready <= !(idle_on && $urandom_range(99) < 21);
        end
    end

    // Offers one observation beat and returns once it has been taken.
    task automatic send_observation(logic signed [19:0] x, logic signed [19:0] y,
                                    logic signed [19:0] z, logic [10:0] rad, logic only);
        bit taken;
        if (idle_on && $urandom_range(99) < 21) begin
            obs_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        obs_valid   <= 1'b1;
        obs_x       <= x;
        obs_y       <= y;
        obs_z       <= z;
        obs_radius  <= rad;
        target_only <= only;
        seen_x = {seen_x, x};
        seen_y = {seen_y, y};
        seen_z = {seen_z, z};
        if (seen_x.size() > 64) begin
            void'(seen_x.pop_front());
            void'(seen_y.pop_front());
            void'(seen_z.pop_front());
        end
        do begin
            @(negedge clk);
            taken = obs_ready;
            @(posedge clk);
        end while (!taken);
    endtask

    // Mostly revisits earlier positions so that matches and spacing rejects happen.
    task automatic send_random_observation();
        int pick, k, spread;
        logic signed [19:0] x, y, z;
        logic [10:0] rad;
        pick   = $urandom_range(99);
        spread = ($urandom_range(1)) ? 400 : 1500;
        if (pick < 55 && seen_x.size() > 0) begin
            k = $urandom_range(seen_x.size() - 1);
            x = seen_x[k] + $signed(20'($urandom_range(2 * spread) - spread));
            y = seen_y[k] + $signed(20'($urandom_range(2 * spread) - spread));
            z = seen_z[k] + $signed(20'($urandom_range(2 * spread) - spread));
        end else if (pick < 85) begin
            x = 20'($urandom);
            y = 20'($urandom);
            z = 20'($urandom);
        end else if (pick < 92) begin
            x = $urandom_range(1) ? 20'sh7FFFF : 20'sh80000;
            y = $urandom_range(1) ? 20'sh7FFFF : 20'sh80000;
            z = $urandom_range(1) ? 20'sh7FFFF : 20'sh80000;
        end else begin
            x = $signed(20'($urandom_range(8000))) - 20'sd4000;
            y = $signed(20'($urandom_range(8000))) - 20'sd4000;
            z = $signed(20'($urandom_range(8000))) - 20'sd4000;
        end
        case ($urandom_range(9))
            0:       rad = 11'd0;
            1:       rad = 11'd2047;
            default: rad = 11'($urandom);
        endcase
        send_observation(x, y, z, rad, $urandom_range(99) < 25);
    endtask

    // Waits with the input channel quiet until every result has come back.
    task automatic drain_results();
        obs_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (10) @(posedge clk);
    endtask

    // Writes all three settings on consecutive edges.
    task automatic set_thresholds(logic [15:0] spacing, logic [15:0] match,
                                  logic [15:0] smooth);
        cfg_we    <= 1'b1;
        cfg_index <= CfgSpacing;
        cfg_data  <= spacing;
        @(posedge clk);
        cfg_index <= CfgMatch;
        cfg_data  <= match;
        @(posedge clk);
        cfg_index <= CfgSmoothing;
        cfg_data  <= smooth;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    initial begin
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = CfgSpacing;
        cfg_data    = '0;
        obs_valid   = 1'b0;
        obs_x       = '0;
        obs_y       = '0;
        obs_z       = '0;
        obs_radius  = '0;
        target_only = 1'b0;
        idle_on     = 1'b1;
        hold_req    = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, add, first and smoothed radius, spacing reject.
        send_observation(20'sd10000, 20'sd0, 20'sd0, 11'd100, 1'b1);
        send_observation(20'sd10000, 20'sd0, 20'sd0, 11'd100, 1'b0);
        send_observation(20'sd10100, 20'sd50, -20'sd50, 11'd2047, 1'b0);
        send_observation(20'sd10100, 20'sd50, -20'sd50, 11'd0, 1'b1);
        send_observation(20'sd10800, 20'sd0, 20'sd0, 11'd5, 1'b0);
        send_observation(20'sh80000, 20'sh80000, 20'sh80000, 11'd2047, 1'b0);
        send_observation(20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF, 11'd0, 1'b0);
        send_observation(20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF, 11'd1024, 1'b0);
        send_observation(20'sd30000, 20'sd0, 20'sd0, 11'd300, 1'b0);
        send_observation(20'sd31200, 20'sd0, 20'sd0, 11'd300, 1'b0);
        send_observation(20'sd30600, 20'sd0, 20'sd0, 11'd300, 1'b0);
        send_observation(-20'sd200000, 20'sd123456, -20'sd77, 11'd1, 1'b1);
        drain_results();

        // Huge match radius, no spacing: ties go to the lower slot.
        set_thresholds(16'd0, 16'hFFFF, 16'd0);
        send_observation(20'sd30600, 20'sd0, 20'sd0, 11'd700, 1'b0);
        for (int i = 0; i < 240; i++) send_random_observation();
        drain_results();

        // Zero match radius and maximal spacing, full weight on the old radius.
        set_thresholds(16'hFFFF, 16'd0, 16'd256);
        idle_on = 1'b0;
        for (int i = 0; i < 240; i++) send_random_observation();
        drain_results();
        idle_on = 1'b1;

        // Weight above full scale saturates; a long result stall fills the block.
        set_thresholds(16'd300, 16'd2000, 16'd511);
        for (int i = 0; i < 240; i++) begin
            if (i == 20) hold_req <= 1'b1;
            send_random_observation();
        end
        drain_results();

        // Settings back at their reset values, then random ones.
        set_thresholds(16'd1000, 16'd500, 16'd205);
        for (int i = 0; i < 240; i++) send_random_observation();
        drain_results();
        set_thresholds(16'($urandom), 16'($urandom_range(4000)), 16'($urandom));
        for (int i = 0; i < 240; i++) send_random_observation();
        drain_results();

        if (fail_count == 0) begin
            $display("landmark_nearest_match_table regression: pass");
        end else begin
            $display("landmark_nearest_match_table regression: fail");
        end
        $finish;
    end

    // Hard stop in case the block hangs.
    initial begin
        #20ms;
        $display("landmark_nearest_match_table regression: fail");
        $finish;
    end

endmodule

// ----- landmark_nearest_match_table.f -----
+incdir+rtl/core
rtl/core/lnm_pkg.sv
rtl/core/lnm_store.sv
rtl/core/lnm_dist.sv
rtl/core/landmark_nearest_match_table.sv
dv/landmark_nearest_match_table_checker.sv
dv/landmark_nearest_match_table_tb.sv
